// ===== sv/mbeg_pkg.sv =====
// Shared types, constants and helper function of the Mandelbrot escape-time grey block.
`default_nettype none

package mbeg_pkg;

   localparam int FRAC_BITS = 28;
   localparam int FX_W      = 32;
   localparam int COL_W     = 15;
   localparam int ROW_W     = 15;
   localparam int STEP_W    = 28;
   localparam int ITER_W    = 10;
   localparam int GREY_W    = 8;

   localparam int PROD_W    = 2 * FX_W;
   localparam int SHP_W     = PROD_W - FRAC_BITS;
   localparam int CP_W      = COL_W + STEP_W;
   localparam int SAT_IN_W  = CP_W + 2;

   localparam int QUOT_W    = GREY_W;
   localparam int DIVD_W    = ITER_W + QUOT_W;
   localparam int DIV_CNT_W = $clog2(QUOT_W);

   localparam int REQ_DATA_W = ((COL_W + ROW_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((GREY_W + ITER_W + 7) / 8) * 8;
   localparam int RSP_USER_W = 1;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [FX_W-1:0] ONE_FX     = FX_W'(1 << FRAC_BITS);
   localparam logic signed [FX_W-1:0] NEG_ONE_FX = -ONE_FX;
   localparam logic signed [FX_W-1:0] QUARTER_FX = FX_W'(1 << (FRAC_BITS - 2));
   localparam logic signed [FX_W-1:0] TWO_FX     = FX_W'(2 << FRAC_BITS);
   localparam logic signed [FX_W-1:0] NEG_TWO_FX = -TWO_FX;
   localparam logic signed [SHP_W:0]  FOUR_FX    = (SHP_W + 1)'(4 << FRAC_BITS);

   localparam logic signed [SAT_IN_W-1:0] SAT_HI =
      SAT_IN_W'((longint'(1) << (FX_W - 1)) - longint'(1));
   localparam logic signed [SAT_IN_W-1:0] SAT_LO =
      SAT_IN_W'(-(longint'(1) << (FX_W - 1)));

   localparam logic [FX_W-1:0]   RST_REAL_ORIGIN = 32'hE000_0000;
   localparam logic [FX_W-1:0]   RST_IMAG_ORIGIN = 32'hF000_0000;
   localparam logic [STEP_W-1:0] RST_PIXEL_STEP  = 28'd26844;
   localparam logic [ITER_W-1:0] RST_MAX_ITER    = 10'd250;

   localparam logic [GREY_W-1:0] GREY_FULL = '1;

   typedef struct packed {
      logic [FX_W-1:0]   real_origin;
      logic [FX_W-1:0]   imag_origin;
      logic [STEP_W-1:0] pixel_step;
      logic [ITER_W-1:0] max_iter;
   } cfg_type;

   typedef enum logic [1:0] {
      CSR_REAL_ORIGIN,
      CSR_IMAG_ORIGIN,
      CSR_PIXEL_STEP,
      CSR_MAX_ITER
   } csr_index_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_LOAD,
      DP_MUL_C,
      DP_SET_C,
      DP_MUL_CARD,
      DP_SUM_CARD,
      DP_MUL_Z,
      DP_CHECK_CARD,
      DP_UPDATE,
      DP_ESCAPE,
      DP_DIV_STEP,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      logic card_in;
      logic escaped;
      logic at_limit;
      logic div_last;
      logic out_free;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_C,
      ST_SET_C,
      ST_MUL_CARD,
      ST_SUM_CARD,
      ST_MUL_Q,
      ST_CHECK_CARD,
      ST_MUL_Z,
      ST_UPDATE,
      ST_DIV,
      ST_DONE
   } ctrl_state_type;

   function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [SAT_IN_W-1:0] v);
      logic signed [FX_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[FX_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[FX_W-1:0];
      end else begin
         r = v[FX_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/mbeg_csr.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module mbeg_csr
   import mbeg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_REAL_ORIGIN: cfg_in.real_origin = csr_pwdata[FX_W-1:0];
            CSR_IMAG_ORIGIN: cfg_in.imag_origin = csr_pwdata[FX_W-1:0];
            CSR_PIXEL_STEP:  cfg_in.pixel_step  = csr_pwdata[STEP_W-1:0];
            CSR_MAX_ITER:    cfg_in.max_iter    = csr_pwdata[ITER_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_REAL_ORIGIN: csr_prdata = CSR_DATA_W'(cfg_ff.real_origin);
         CSR_IMAG_ORIGIN: csr_prdata = CSR_DATA_W'(cfg_ff.imag_origin);
         CSR_PIXEL_STEP:  csr_prdata = CSR_DATA_W'(cfg_ff.pixel_step);
         CSR_MAX_ITER:    csr_prdata = CSR_DATA_W'(cfg_ff.max_iter);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.real_origin <= RST_REAL_ORIGIN;
         cfg_ff.imag_origin <= RST_IMAG_ORIGIN;
         cfg_ff.pixel_step  <= RST_PIXEL_STEP;
         cfg_ff.max_iter    <= RST_MAX_ITER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mbeg_ctrl.sv =====
// Sequencing state machine that issues datapath commands for one pixel.
`default_nettype none

module mbeg_ctrl
   import mbeg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output dp_op_type          cmd,
   output ctrl_state_type     state
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   assign state = state_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MUL_C;
            end
         end
         ST_MUL_C:    state_in = ST_SET_C;
         ST_SET_C:    state_in = ST_MUL_CARD;
         ST_MUL_CARD: state_in = ST_SUM_CARD;
         ST_SUM_CARD: state_in = ST_MUL_Q;
         ST_MUL_Q:    state_in = ST_CHECK_CARD;
         ST_CHECK_CARD: begin
            state_in = status.card_in ? ST_DONE : ST_MUL_Z;
         end
         ST_MUL_Z:    state_in = ST_UPDATE;
         ST_UPDATE: begin
            priority if (status.escaped) begin
               state_in = ST_DIV;
            end else if (status.at_limit) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL_Z;
            end
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = DP_IDLE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd = DP_LOAD;
            end
         end
         ST_MUL_C:      cmd = DP_MUL_C;
         ST_SET_C:      cmd = DP_SET_C;
         ST_MUL_CARD:   cmd = DP_MUL_CARD;
         ST_SUM_CARD:   cmd = DP_SUM_CARD;
         ST_MUL_Q:      cmd = DP_MUL_Z;
         ST_CHECK_CARD: cmd = DP_CHECK_CARD;
         ST_MUL_Z:      cmd = DP_MUL_Z;
         ST_UPDATE: begin
            priority if (status.escaped) begin
               cmd = DP_ESCAPE;
            end else if (status.at_limit) begin
               cmd = DP_IDLE;
            end else begin
               cmd = DP_UPDATE;
            end
         end
         ST_DIV:        cmd = DP_DIV_STEP;
         ST_DONE: begin
            if (status.out_free) begin
               cmd = DP_FINISH;
            end
         end
         default:       cmd = DP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mbeg_dpath.sv =====
// Fixed-point datapath: point setup, cardioid test, z iteration, grey divider and output register.
`default_nettype none

module mbeg_dpath
   import mbeg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire dp_op_type         cmd,
   output dp_status_type          status,
   input  wire logic [COL_W-1:0]  req_col,
   input  wire logic [ROW_W-1:0]  req_row,
   input  wire logic              rsp_tready,
   output logic                   rsp_tvalid,
   output logic [GREY_W-1:0]      rsp_grey,
   output logic [ITER_W-1:0]      rsp_count,
   output logic                   rsp_inside
);

   logic [COL_W-1:0]           col_ff, col_in;
   logic [ROW_W-1:0]           row_ff, row_in;
   logic signed [FX_W-1:0]     cr_ff, cr_in;
   logic signed [FX_W-1:0]     ci_ff, ci_in;
   logic signed [FX_W-1:0]     re_ff, re_in;
   logic signed [FX_W-1:0]     im_ff, im_in;
   logic signed [FX_W-1:0]     rhs_ff, rhs_in;
   logic signed [PROD_W-1:0]   prod0_ff, prod0_in;
   logic signed [PROD_W-1:0]   prod1_ff, prod1_in;
   logic signed [PROD_W-1:0]   prod2_ff, prod2_in;
   logic [ITER_W-1:0]          n_ff, n_in;
   logic [DIVD_W-1:0]          rem_ff, rem_in;
   logic [DIVD_W-1:0]          dvs_ff, dvs_in;
   logic [QUOT_W-1:0]          quot_ff, quot_in;
   logic [DIV_CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [ITER_W-1:0]          res_count_ff, res_count_in;
   logic                       res_inside_ff, res_inside_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [GREY_W-1:0]          rsp_grey_ff, rsp_grey_in;
   logic [ITER_W-1:0]          rsp_count_ff, rsp_count_in;
   logic                       rsp_inside_ff, rsp_inside_in;

   logic signed [FX_W-1:0]     m0_a, m0_b, m1_a, m1_b;
   logic signed [FX_W-1:0]     col_op, row_op, step_op, xm;
   logic signed [SHP_W-1:0]    rr, ii, ri;
   logic signed [SHP_W:0]      mag;
   logic signed [FX_W-1:0]     new_re, new_im, c_re, c_im, q_val;
   logic                       bound_out, box_in, div_ge;
   logic [ITER_W-1:0]          esc_idx;

   assign col_op  = $signed({{(FX_W-COL_W){1'b0}}, col_ff});
   assign row_op  = $signed({{(FX_W-ROW_W){1'b0}}, row_ff});
   assign step_op = $signed({{(FX_W-STEP_W){1'b0}}, cfg.pixel_step});
   assign xm      = cr_ff - QUARTER_FX;

   always_comb begin
      unique case (cmd)
         DP_MUL_C: begin
            m0_a = col_op;
            m0_b = step_op;
            m1_a = row_op;
            m1_b = step_op;
         end
         DP_MUL_CARD: begin
            m0_a = xm;
            m0_b = xm;
            m1_a = ci_ff;
            m1_b = ci_ff;
         end
         default: begin
            m0_a = re_ff;
            m0_b = re_ff;
            m1_a = im_ff;
            m1_b = im_ff;
         end
      endcase
   end

   assign rr = $signed(prod0_ff[PROD_W-1:FRAC_BITS]);
   assign ii = $signed(prod1_ff[PROD_W-1:FRAC_BITS]);
   assign ri = $signed(prod2_ff[PROD_W-1:FRAC_BITS]);

   assign mag       = (SHP_W + 1)'(rr) + (SHP_W + 1)'(ii);
   assign bound_out = (re_ff > TWO_FX) || (re_ff < NEG_TWO_FX) ||
                      (im_ff > TWO_FX) || (im_ff < NEG_TWO_FX);
   assign new_re    = sat_fx(SAT_IN_W'(rr) - SAT_IN_W'(ii) + SAT_IN_W'(cr_ff));
   assign new_im    = sat_fx((SAT_IN_W'(ri) <<< 1) + SAT_IN_W'(ci_ff));

   assign c_re = sat_fx(SAT_IN_W'($signed(cfg.real_origin)) +
                        SAT_IN_W'($signed({1'b0, prod0_ff[CP_W-1:0]})));
   assign c_im = sat_fx(SAT_IN_W'($signed(cfg.imag_origin)) +
                        SAT_IN_W'($signed({1'b0, prod1_ff[CP_W-1:0]})));

   assign q_val  = mag[FX_W-1:0];
   assign box_in = (cr_ff >= NEG_ONE_FX) && (cr_ff <= ONE_FX) &&
                   (ci_ff >= NEG_ONE_FX) && (ci_ff <= ONE_FX);

   assign esc_idx = n_ff - ITER_W'(1);
   assign div_ge  = rem_ff >= dvs_ff;

   assign status.card_in  = box_in && (ri <= SHP_W'(rhs_ff));
   assign status.escaped  = (n_ff != '0) && (bound_out || (mag > FOUR_FX));
   assign status.at_limit = n_ff == cfg.max_iter;
   assign status.div_last = div_cnt_ff == DIV_CNT_W'(QUOT_W - 1);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign prod2_in = (cmd == DP_MUL_Z) ? re_ff * im_ff : prod2_ff;

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      re_in         = re_ff;
      im_in         = im_ff;
      rhs_in        = rhs_ff;
      prod0_in      = prod0_ff;
      prod1_in      = prod1_ff;
      n_in          = n_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      quot_in       = quot_ff;
      div_cnt_in    = div_cnt_ff;
      res_count_in  = res_count_ff;
      res_inside_in = res_inside_ff;
      rsp_grey_in   = rsp_grey_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      unique case (cmd)
         DP_IDLE: begin
         end
         DP_LOAD: begin
            col_in = req_col;
            row_in = req_row;
         end
         DP_MUL_C, DP_MUL_CARD, DP_MUL_Z: begin
            prod0_in = m0_a * m0_b;
            prod1_in = m1_a * m1_b;
         end
         DP_SET_C: begin
            cr_in = c_re;
            ci_in = c_im;
         end
         DP_SUM_CARD: begin
            re_in  = q_val;
            im_in  = q_val + xm;
            rhs_in = $signed(ii[FX_W+1:2]);
         end
         DP_CHECK_CARD: begin
            re_in         = '0;
            im_in         = '0;
            n_in          = '0;
            res_inside_in = 1'b1;
            res_count_in  = cfg.max_iter;
         end
         DP_UPDATE: begin
            re_in = new_re;
            im_in = new_im;
            n_in  = n_ff + ITER_W'(1);
         end
         DP_ESCAPE: begin
            res_inside_in = 1'b0;
            res_count_in  = esc_idx;
            rem_in        = {esc_idx, {QUOT_W{1'b0}}} - DIVD_W'(esc_idx);
            dvs_in        = {1'b0, cfg.max_iter, {(QUOT_W-1){1'b0}}};
            div_cnt_in    = '0;
         end
         DP_DIV_STEP: begin
            rem_in     = div_ge ? rem_ff - dvs_ff : rem_ff;
            quot_in    = {quot_ff[QUOT_W-2:0], div_ge};
            dvs_in     = dvs_ff >> 1;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         DP_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_grey_in   = res_inside_ff ? GREY_FULL : quot_ff;
            rsp_count_in  = res_count_ff;
            rsp_inside_in = res_inside_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      row_ff        <= row_in;
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      re_ff         <= re_in;
      im_ff         <= im_in;
      rhs_ff        <= rhs_in;
      prod0_ff      <= prod0_in;
      prod1_ff      <= prod1_in;
      prod2_ff      <= prod2_in;
      n_ff          <= n_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      quot_ff       <= quot_in;
      div_cnt_ff    <= div_cnt_in;
      res_count_ff  <= res_count_in;
      res_inside_ff <= res_inside_in;
      rsp_grey_ff   <= rsp_grey_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_grey   = rsp_grey_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_inside = rsp_inside_ff;

endmodule

`default_nettype wire

// ===== sv/mandelbrot_escape_time_grey.sv =====
// Top level of the Mandelbrot escape-time grey block: streams, register port and assertions.
//
// Channel   Direction  Handshake                  Payload
// req       in         req_tvalid / req_tready    tdata: pixel_column, pixel_row
// rsp       out        rsp_tvalid / rsp_tready    tdata: grey_level, escape_count; tuser: inside_set
// csr       in         psel, penable, pready      register write and read, 32-bit data
//
// One pixel is worked on at a time: setup of the point and the cardioid test, then up to max_iter + 1
// passes of the multiplier loop, the 8 steps of the radix-2 grey divider when the point escapes,
// and the load of the output register once that register is free.
// The next transaction is taken in the idle state that follows.
// A new transaction is taken while the previous result still waits in the output register.
// Reset sets the configuration registers to their defaults and empties the output register.
`default_nettype none

module mandelbrot_escape_time_grey
   import mbeg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // pixel_column [14:0], pixel_row [29:15], zero fill [31:30]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // grey_level [7:0], escape_count [17:8], zero fill [23:18]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // inside_set [0]
   output logic [RSP_USER_W-1:0]      rsp_tuser,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   cfg_type           cfg;
   dp_op_type         cmd;
   dp_status_type     status;
   ctrl_state_type    state;
   logic [GREY_W-1:0] rsp_grey;
   logic [ITER_W-1:0] rsp_count;
   logic              rsp_inside;

   mbeg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mbeg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .state      (state)
   );

   mbeg_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_col    (req_tdata[COL_W-1:0]),
      .req_row    (req_tdata[COL_W+ROW_W-1:COL_W]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_grey   (rsp_grey),
      .rsp_count  (rsp_count),
      .rsp_inside (rsp_inside)
   );

   assign rsp_tdata = {{(RSP_DATA_W-GREY_W-ITER_W){1'b0}}, rsp_count, rsp_grey};
   assign rsp_tuser = rsp_inside;

`ifndef SYNTHESIS
   a_inside_full_grey: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_inside) |-> (rsp_grey == GREY_FULL))
      else $error("Inside result without full grey level.");

   a_escape_below_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_inside) |-> (rsp_count < cfg.max_iter && rsp_grey != GREY_FULL))
      else $error("Escaped result with count or grey level out of range.");

   a_finish_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (state == ST_DONE && rsp_tvalid && !rsp_tready) |=> (state == ST_DONE))
      else $error("Result left the controller while the output register was full.");
`endif

endmodule

`default_nettype wire
